// ===== hw/rtl/fxalu_pkg.sv =====
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared widths, opcodes, stage structs and helpers of the Q17.14 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 14;
	localparam int KIND_W    = 3;
	localparam int NUM_W     = DATA_W + FRAC_BITS;   // scaled dividend width, one cell per bit
	localparam int PROD_W    = 2 * DATA_W;

	localparam logic [DATA_W:0] HALF = (DATA_W + 1)'(1) << (FRAC_BITS - 1);

	typedef enum logic [KIND_W-1:0] {
		OP_TO_FIXED = 3'd0,
		OP_TRUNC    = 3'd1,
		OP_ROUND    = 3'd2,
		OP_ADD_INT  = 3'd3,
		OP_MUL      = 3'd4,
		OP_DIV      = 3'd5
	} op_t;

	// side information that rides along the divider chain
	typedef struct packed {
		logic              is_div;
		logic              neg;
		logic              dz;
		logic [DATA_W-1:0] res;
	} side_t;

	// restoring division state of one cell
	typedef struct packed {
		logic [DATA_W:0]   rem;
		logic [NUM_W-1:0]  num;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] dvs;
	} div_t;

	typedef struct packed {
		logic [DATA_W-1:0] res;
		logic              dz;
	} result_t;

	function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [DATA_W-1:0] apply_sign(input logic neg,
			input logic [DATA_W-1:0] m);
		return neg ? (~m + 1'b1) : m;
	endfunction

endpackage

// ===== hw/rtl/fxalu_if.sv =====
// ----------------------------------------------------------------------------
// fxalu_if
// Valid/ready channels of the fixed-point ALU: request and response.
// ----------------------------------------------------------------------------
interface fxalu_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [fxalu_pkg::KIND_W-1:0]           kind;
	logic signed [fxalu_pkg::DATA_W-1:0]    operand_a;
	logic signed [fxalu_pkg::DATA_W-1:0]    operand_b;

	modport source (output valid, output kind, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input kind, input operand_a, input operand_b,
		output ready);
endinterface

interface fxalu_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [fxalu_pkg::DATA_W-1:0]    result_value;
	logic                                   divide_by_zero;

	modport source (output valid, output result_value, output divide_by_zero,
		input ready);
	modport sink (input valid, input result_value, input divide_by_zero,
		output ready);
endinterface

// ===== hw/rtl/fxalu_prep.sv =====
// ----------------------------------------------------------------------------
// fxalu_prep
// Front stages: decode, magnitudes, simple ops, registered multiply, divider setup.
// ----------------------------------------------------------------------------
module fxalu_prep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	fxalu_req_if.sink              req,
	output logic                   valid_s3,
	output fxalu_pkg::side_t       side_s3,
	output fxalu_pkg::div_t        div_s3
);

	localparam int W = fxalu_pkg::DATA_W;

	logic [W-1:0]      a, b, mag_a, mag_b, simple_res;
	logic [W:0]        round_sum, round_sh;
	logic [W-1:0]      trunc_mag;
	fxalu_pkg::op_t    op;

	logic              valid_s1, valid_s2;
	fxalu_pkg::op_t    op_s1, op_s2;
	logic              neg_s1, neg_s2;
	logic [W-1:0]      mag_a_s1, mag_b_s1;
	logic [W-1:0]      res_s1, res_s2;
	fxalu_pkg::div_t   div_s1, div_s2;
	logic [fxalu_pkg::PROD_W-1:0] prod_s2, prod_sh;

	assign req.ready = en;

	assign a     = req.operand_a;
	assign b     = req.operand_b;
	assign op    = fxalu_pkg::op_t'(req.kind);
	assign mag_a = fxalu_pkg::mag(a);
	assign mag_b = fxalu_pkg::mag(b);

	assign trunc_mag = mag_a >> fxalu_pkg::FRAC_BITS;
	assign round_sum = {1'b0, mag_a} + fxalu_pkg::HALF;
	assign round_sh  = round_sum >> fxalu_pkg::FRAC_BITS;

	always_comb begin
		case (op)
			fxalu_pkg::OP_TO_FIXED: simple_res = b << fxalu_pkg::FRAC_BITS;
			fxalu_pkg::OP_TRUNC:    simple_res = fxalu_pkg::apply_sign(a[W-1], trunc_mag);
			fxalu_pkg::OP_ROUND:    simple_res = fxalu_pkg::apply_sign(a[W-1],
				round_sh[W-1:0]);
			fxalu_pkg::OP_ADD_INT:  simple_res = a + (b << fxalu_pkg::FRAC_BITS);
			default:                simple_res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= op;
			neg_s1   <= a[W-1] ^ b[W-1];
			mag_a_s1 <= mag_a;
			mag_b_s1 <= mag_b;
			res_s1   <= simple_res;
			div_s1.rem <= '0;
			div_s1.num <= {mag_a, {fxalu_pkg::FRAC_BITS{1'b0}}};
			div_s1.quo <= '0;
			div_s1.dvs <= mag_b;

			op_s2   <= op_s1;
			neg_s2  <= neg_s1;
			res_s2  <= res_s1;
			div_s2  <= div_s1;
			prod_s2 <= mag_a_s1 * mag_b_s1;

			side_s3.is_div <= (op_s2 == fxalu_pkg::OP_DIV);
			side_s3.neg    <= neg_s2;
			side_s3.dz     <= (op_s2 == fxalu_pkg::OP_DIV) && (div_s2.dvs == '0);
			side_s3.res    <= (op_s2 == fxalu_pkg::OP_MUL) ?
				fxalu_pkg::apply_sign(neg_s2, prod_sh[W-1:0]) : res_s2;
			div_s3 <= div_s2;
		end
	end

	assign prod_sh = prod_s2 >> fxalu_pkg::FRAC_BITS;

endmodule

// ===== hw/rtl/fxalu_div_cell.sv =====
// ----------------------------------------------------------------------------
// fxalu_div_cell
// One restoring-division step: shifts in a dividend bit, emits one quotient bit.
// ----------------------------------------------------------------------------
module fxalu_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_in,
	input  fxalu_pkg::side_t       side_in,
	input  fxalu_pkg::div_t        div_in,
	output logic                   valid_q,
	output fxalu_pkg::side_t       side_q,
	output fxalu_pkg::div_t        div_q
);

	localparam int W = fxalu_pkg::DATA_W;

	logic [W:0]   trial;
	logic [W+1:0] diff;
	logic         ge;

	assign trial = {div_in.rem[W-1:0], div_in.num[fxalu_pkg::NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_in.dvs};
	assign ge    = ~diff[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q     <= side_in;
			div_q.rem  <= ge ? diff[W:0] : trial;
			div_q.num  <= div_in.num << 1;
			div_q.quo  <= {div_in.quo[W-2:0], ge};
			div_q.dvs  <= div_in.dvs;
		end
	end

endmodule

// ===== hw/rtl/fxalu_skid.sv =====
// ----------------------------------------------------------------------------
// fxalu_skid
// Output register plus one skid entry; stalls the pipeline only when both are full.
// ----------------------------------------------------------------------------
module fxalu_skid (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	input  fxalu_pkg::result_t     up_data,
	output logic                   up_ready,
	fxalu_rsp_if.source            rsp
);

	logic                 out_valid_q, skid_valid_q;
	fxalu_pkg::result_t   out_q, skid_q;
	logic                 take, pop;

	assign up_ready = ~skid_valid_q;
	assign take     = up_valid & up_ready;
	assign pop      = out_valid_q & rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (take) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (take) begin
			if (!out_valid_q || pop) begin
				out_q <= up_data;
			end else begin
				skid_q <= up_data;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_value   = out_q.res;
	assign rsp.divide_by_zero = out_q.dz;

endmodule

// ===== hw/rtl/fixed_point_q17_14_alu.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q17_14_alu
// Signed Q17.14 fixed-point ALU: convert, truncate, round, add, multiply, divide.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless the pipeline holds; every op walks
//   the same division chain, one quotient bit per cell, so results leave in request order.
// The whole pipeline advances together; it holds only when the output register
//   and its skid entry both carry unclaimed results.
// Reset: arst_n clears all valid flags at once; payload registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_q17_14_alu (
	input  logic          clk,
	input  logic          arst_n,
	fxalu_req_if.sink     req,
	fxalu_rsp_if.source   rsp
);

	localparam int N = fxalu_pkg::NUM_W;

	// global stage enable, from the output skid
	logic en;

	// chain taps: index 0 is the front end, index N the last cell
	logic               valid_c [0:N];
	fxalu_pkg::side_t   side_c  [0:N];
	fxalu_pkg::div_t    div_c   [0:N];

	fxalu_pkg::result_t fin;

	// decode, simple ops, registered multiply, divider setup (three stages)
	fxalu_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.req      (req),
		.valid_s3 (valid_c[0]),
		.side_s3  (side_c[0]),
		.div_s3   (div_c[0])
	);

	// one restoring-division cell per bit of the scaled dividend;
	// non-divide transactions just ride along with their finished result
	for (genvar i = 0; i < N; i++) begin : g_cell
		fxalu_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (valid_c[i]),
			.side_in  (side_c[i]),
			.div_in   (div_c[i]),
			.valid_q  (valid_c[i+1]),
			.side_q   (side_c[i+1]),
			.div_q    (div_c[i+1])
		);
	end

	// final pick: carried result for other ops, signed quotient for divide, zero on a zero divisor
	always_comb begin
		fin.dz = side_c[N].dz;
		if (!side_c[N].is_div) begin
			fin.res = side_c[N].res;
		end else if (side_c[N].dz) begin
			fin.res = '0;
		end else begin
			fin.res = fxalu_pkg::apply_sign(side_c[N].neg, div_c[N].quo);
		end
	end

	fxalu_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[N]),
		.up_data  (fin),
		.up_ready (en),
		.rsp      (rsp)
	);

endmodule

// ===== sim/tb_fixed_point_q17_14_alu.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_point_q17_14_alu
// Self-checking bench for the Q17.14 ALU. A directed set of corner operations
// is followed by random traffic. Both channels take random idle bursts. Each
// response is checked against a local fixed-point predictor, in order.
// ----------------------------------------------------------------------------
module tb_fixed_point_q17_14_alu;

	// opcodes the ALU does not define; both must return zero with no flag
	localparam logic [fxalu_pkg::KIND_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [fxalu_pkg::KIND_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_REQUESTS = 1850;
	localparam int CALM_TAIL       = 150;   // last requests run without idling
	localparam int PIPE_DRAIN      = 64;    // covers the request-to-response latency
	localparam int STALL_LIMIT     = 2000;  // cycles with no transaction at all
	localparam int REPORT_MAX      = 10;

	typedef struct {
		logic [fxalu_pkg::KIND_W-1:0] kind;
		logic [fxalu_pkg::DATA_W-1:0] a;
		logic [fxalu_pkg::DATA_W-1:0] b;
		bit                           drain;   // hold this one until the pipe has emptied
	} alu_request_t;

	logic clk;
	logic arst_n;

	fxalu_req_if req();
	fxalu_rsp_if rsp();

	fixed_point_q17_14_alu i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	alu_request_t         pending_requests[$];
	fxalu_pkg::result_t   expected_results[$];

	alu_request_t         next_req;
	fxalu_pkg::result_t   want;
	int                   send_gap;
	int                   ready_stall;
	int                   accepted_count;
	int                   checked_count;
	int                   error_count;
	int                   zero_div_count;
	int                   idle_cycles;
	int                   op_seen[8];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor: sign-magnitude arithmetic at 64 bits, truncation toward zero,
	// low 32 bits kept.
	// ------------------------------------------------------------------------
	function automatic logic [63:0] magnitude64(input logic [fxalu_pkg::DATA_W-1:0] v);
		logic [fxalu_pkg::DATA_W-1:0] pos;
		pos = v[fxalu_pkg::DATA_W-1] ? (~v + 1'b1) : v;
		return {32'b0, pos};
	endfunction

	function automatic logic [fxalu_pkg::DATA_W-1:0] signed_wrap(input logic negative,
			input logic [63:0] m);
		logic [63:0] r;
		r = negative ? (~m + 64'd1) : m;
		return r[fxalu_pkg::DATA_W-1:0];
	endfunction

	function automatic fxalu_pkg::result_t alu_expected(
			input logic [fxalu_pkg::KIND_W-1:0] kind,
			input logic [fxalu_pkg::DATA_W-1:0] a,
			input logic [fxalu_pkg::DATA_W-1:0] b);
		fxalu_pkg::result_t r;
		logic [63:0]        ma;
		logic [63:0]        mb;
		logic [63:0]        half_lsb;
		logic               sa;
		logic               sb;
		ma       = magnitude64(a);
		mb       = magnitude64(b);
		sa       = a[fxalu_pkg::DATA_W-1];
		sb       = b[fxalu_pkg::DATA_W-1];
		half_lsb = 64'd1 << (fxalu_pkg::FRAC_BITS - 1);
		r.res    = '0;
		r.dz     = 1'b0;
		case (kind)
			fxalu_pkg::OP_TO_FIXED: r.res = b << fxalu_pkg::FRAC_BITS;
			fxalu_pkg::OP_TRUNC:    r.res = signed_wrap(sa, ma >> fxalu_pkg::FRAC_BITS);
			// half step added at 64 bits, so the top of the range cannot overflow
			fxalu_pkg::OP_ROUND:    r.res = signed_wrap(sa,
					(ma + half_lsb) >> fxalu_pkg::FRAC_BITS);
			fxalu_pkg::OP_ADD_INT:  r.res = a + (b << fxalu_pkg::FRAC_BITS);
			fxalu_pkg::OP_MUL:      r.res = signed_wrap(sa ^ sb,
					(ma * mb) >> fxalu_pkg::FRAC_BITS);
			fxalu_pkg::OP_DIV: begin
				if (b == '0) begin
					r.dz = 1'b1;
				end else begin
					r.res = signed_wrap(sa ^ sb, (ma << fxalu_pkg::FRAC_BITS) / mb);
				end
			end
			default:                r.res = '0;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic add_request(input logic [fxalu_pkg::KIND_W-1:0] kind,
			input logic [fxalu_pkg::DATA_W-1:0] a,
			input logic [fxalu_pkg::DATA_W-1:0] b, input bit drain = 1'b0);
		alu_request_t item;
		item.kind  = kind;
		item.a     = a;
		item.b     = b;
		item.drain = drain;
		pending_requests.push_back(item);
	endtask

	// mix of corners, small values, exact halves and full-range noise
	function automatic logic [fxalu_pkg::DATA_W-1:0] pick_operand();
		int s;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 8))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h7FFF_FFFF;
					4: return 32'h8000_0000;
					5: return 32'h0000_4000;
					6: return 32'hFFFF_C000;
					7: return 32'h0000_2000;
					default: return 32'hFFFF_E000;
				endcase
			end
			1, 2: begin
				s = int'($urandom_range(0, 262144)) - 131072;   // about +/-8.0
				return s;
			end
			3: begin
				s = int'($urandom_range(0, 128)) - 64;          // small integer
				return s;
			end
			4: return ($urandom() & 32'hFFFF_C000) | 32'h0000_2000;   // exact .5
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [fxalu_pkg::KIND_W-1:0] pick_kind();
		int unsigned r;
		r = $urandom_range(0, 31);
		if (r < 30)
			return fxalu_pkg::KIND_W'(r % 6);
		return r[0] ? OP_SPARE_HI : OP_SPARE_LO;
	endfunction

	// idling is off in every fourth window of 300 transactions and in the tail
	function automatic bit idling_on();
		return pending_requests.size() >= CALM_TAIL && ((accepted_count / 300) % 4) != 3;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: predicts each request as it is accepted, then refills the slot.
	// A drain-marked request waits until every prediction has been checked.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid     <= 1'b0;
			req.kind      <= '0;
			req.operand_a <= '0;
			req.operand_b <= '0;
			send_gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(alu_expected(req.kind, req.operand_a,
					req.operand_b));
				op_seen[req.kind]++;
				accepted_count++;
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (pending_requests.size() == 0) begin
					req.valid <= 1'b0;
				end else if (pending_requests[0].drain && expected_results.size() != 0) begin
					req.valid <= 1'b0;
				end else begin
					next_req = pending_requests.pop_front();
					req.valid     <= 1'b1;
					req.kind      <= next_req.kind;
					req.operand_a <= next_req.a;
					req.operand_b <= next_req.b;
					if (idling_on() && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 13);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each response against the oldest prediction and
	// throttles ready in random bursts.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			ready_stall = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				checked_count++;
				if (rsp.divide_by_zero)
					zero_div_count++;
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("unexpected response: value %h div0 %b",
							rsp.result_value, rsp.divide_by_zero);
				end else begin
					want = expected_results.pop_front();
					if (rsp.result_value !== want.res || rsp.divide_by_zero !== want.dz) begin
						error_count++;
						if (error_count <= REPORT_MAX)
							$display({"mismatch on response %0d: value exp %h got %h,",
								" div0 exp %b got %b"},
								checked_count, want.res, rsp.result_value,
								want.dz, rsp.divide_by_zero);
					end
				end
			end
			if (ready_stall > 0) begin
				ready_stall--;
				rsp.ready <= 1'b0;
			end else if (idling_on() && $urandom_range(0, 7) == 0) begin
				ready_stall = $urandom_range(1, 13) - 1;   // this cycle is the first
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog: a long stretch with no transaction on either channel is a hang
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: %0d cycles without a transaction", STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sequence: reset, directed corners, random traffic, drain, verdict.
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		accepted_count = 0;
		checked_count  = 0;
		error_count    = 0;
		zero_div_count = 0;
		foreach (op_seen[i])
			op_seen[i] = 0;

		// conversion, including wrap of large integers
		add_request(fxalu_pkg::OP_TO_FIXED, 32'h0, 32'h0000_0001);
		add_request(fxalu_pkg::OP_TO_FIXED, 32'h0, 32'h7FFF_FFFF);
		add_request(fxalu_pkg::OP_TO_FIXED, 32'h0, 32'h8000_0000);
		// truncation toward zero: -tiny gives 0, not -1
		add_request(fxalu_pkg::OP_TRUNC, 32'h7FFF_FFFF, 32'h0);
		add_request(fxalu_pkg::OP_TRUNC, 32'h8000_0000, 32'hFFFF_FFFF);
		add_request(fxalu_pkg::OP_TRUNC, 32'hFFFF_FFFF, 32'h1234_5678);
		// rounding: top of range, bottom of range, both exact halves
		add_request(fxalu_pkg::OP_ROUND, 32'h7FFF_FFFF, 32'h0);
		add_request(fxalu_pkg::OP_ROUND, 32'h8000_0000, 32'h0);
		add_request(fxalu_pkg::OP_ROUND, 32'h0000_2000, 32'h0);
		add_request(fxalu_pkg::OP_ROUND, 32'hFFFF_E000, 32'h0);
		// add with wrap in both directions
		add_request(fxalu_pkg::OP_ADD_INT, 32'h7FFF_FFFF, 32'h0000_0001);
		add_request(fxalu_pkg::OP_ADD_INT, 32'h8000_0000, 32'hFFFF_FFFF);
		// products at the extremes and a tiny negative product
		add_request(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		add_request(fxalu_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_request(fxalu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
		// division: most negative by -1.0, zero divisors, 1/3, smallest divisor
		add_request(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_C000);
		add_request(fxalu_pkg::OP_DIV, 32'h0000_4000, 32'h0000_0000);
		add_request(fxalu_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000);
		add_request(fxalu_pkg::OP_DIV, 32'h0000_4000, 32'h0000_C000);
		add_request(fxalu_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
		// undefined opcodes with busy operands
		add_request(OP_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(OP_SPARE_HI, 32'h8000_0000, 32'h0000_0000);

		// random part; two requests wait for an empty pipe first
		for (int n = 0; n < RANDOM_REQUESTS; n++)
			add_request(pick_kind(), pick_operand(), pick_operand(),
				n == 0 || n == RANDOM_REQUESTS / 2);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || req.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);

		if (expected_results.size() != 0) begin
			error_count++;
			$display("%0d predicted results never arrived", expected_results.size());
		end

		$display("covered %0d transactions: to_fixed %0d, trunc %0d, round %0d, add %0d,",
			accepted_count, op_seen[fxalu_pkg::OP_TO_FIXED], op_seen[fxalu_pkg::OP_TRUNC],
			op_seen[fxalu_pkg::OP_ROUND], op_seen[fxalu_pkg::OP_ADD_INT]);
		$display("  mul %0d, div %0d, undefined %0d; checked %0d, %0d zero divisors, %0d errors",
			op_seen[fxalu_pkg::OP_MUL], op_seen[fxalu_pkg::OP_DIV],
			op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI],
			checked_count, zero_div_count, error_count);

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
